### rtl/tesp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the escape parser.
package tesp_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int MAX_PARAMS_DEF  = 16;
  localparam int PARAM_BITS_DEF  = 16;

  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBR    = 8'h5B;  // '['
  localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_QMARK  = 8'h3F;  // '?'
  localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
  localparam logic [7:0] CH_AT     = 8'h40;  // '@'
  localparam logic [7:0] CH_B      = 8'h42;  // 'B'
  localparam logic [7:0] CH_Z      = 8'h7A;  // 'z'
  localparam logic [7:0] CH_0      = 8'h30;  // '0'
  localparam logic [7:0] CH_9      = 8'h39;  // '9'

  typedef enum logic [2:0] {
    KIND_PRINT  = 3'd0,
    KIND_ESC    = 3'd1,
    KIND_CSI    = 3'd2,
    KIND_HASH   = 3'd3,
    KIND_CS_OK  = 3'd4,
    KIND_CS_BAD = 3'd5
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  open_csi;   // start a fresh CSI parameter list
    logic  set_q;      // note the private marker
    logic  push;       // fold a digit or separator into the list
    logic  out_load;   // load a single non-CSI result
    kind_t out_kind;
    logic  csi_start;  // load the first CSI result, clear the list
    logic  csi_next;   // load the next stored parameter
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_esc;
    logic is_lbr;
    logic is_hash;
    logic is_paren;
    logic is_digit;
    logic is_q;
    logic is_semi;
    logic esc_final;
    logic csi_final;
    logic cs_ok;
    logic out_free;
    logic cnt_le1;
    logic emit_last;
  } sts_t;

endpackage

### rtl/tesp_ctrl.sv
// Parser mode state machine: decodes each byte class into datapath commands.
module tesp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  tesp_pkg::sts_t  sts,
  output tesp_pkg::cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_ESC     = 6'b000010,
    S_CSI     = 6'b000100,
    S_HASH    = 6'b001000,
    S_CHARSET = 6'b010000,
    S_EMIT    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign s_tready = sts.out_free && (state != S_EMIT);
  assign take     = s_tvalid && s_tready;

  always_comb begin
    cmd          = '0;
    cmd.out_kind = tesp_pkg::KIND_PRINT;
    state_next   = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (sts.is_esc) begin
            state_next = S_ESC;
          end else begin
            cmd.out_load = 1'b1;
          end
        end
      end
      S_ESC: begin
        if (take) begin
          if (sts.is_lbr) begin
            cmd.open_csi = 1'b1;
            state_next   = S_CSI;
          end else if (sts.is_hash) begin
            state_next = S_HASH;
          end else if (sts.is_paren) begin
            state_next = S_CHARSET;
          end else if (sts.esc_final) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = tesp_pkg::KIND_ESC;
            state_next   = S_IDLE;
          end else begin
            cmd.out_load = 1'b1;
          end
        end
      end
      S_HASH: begin
        if (take) begin
          cmd.out_load = 1'b1;
          if (sts.is_digit) begin
            cmd.out_kind = tesp_pkg::KIND_HASH;
            state_next   = S_IDLE;
          end
        end
      end
      S_CHARSET: begin
        if (take) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = sts.cs_ok ? tesp_pkg::KIND_CS_OK : tesp_pkg::KIND_CS_BAD;
          state_next   = S_IDLE;
        end
      end
      S_CSI: begin
        if (take) begin
          if (sts.is_q) begin
            cmd.set_q = 1'b1;
          end else if (sts.is_semi || sts.is_digit) begin
            cmd.push = 1'b1;
          end else if (sts.csi_final) begin
            cmd.csi_start = 1'b1;
            state_next    = sts.cnt_le1 ? S_IDLE : S_EMIT;
          end else begin
            cmd.out_load = 1'b1;
          end
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.csi_next = 1'b1;
          if (sts.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/tesp_dp.sv
// Byte classifier, CSI parameter accumulator and store, and the result register.
module tesp_dp #(
  parameter int STACK_DEPTH = tesp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_PARAMS  = tesp_pkg::MAX_PARAMS_DEF,
  parameter int PARAM_BITS  = tesp_pkg::PARAM_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      ch,
  input  tesp_pkg::cmd_t  cmd,
  output tesp_pkg::sts_t  sts,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [39:0]     m_tdata,
  output logic [2:0]      m_tuser,
  output logic            m_tlast
);

  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int XW = PARAM_BITS + 4;
  localparam logic [PARAM_BITS-1:0] MAXV = {PARAM_BITS{1'b1}};

  logic                  question;
  logic [PW-1:0]         pushed;
  logic [CW-1:0]         used;
  logic                  pending;
  logic [PARAM_BITS-1:0] cur_val;
  logic [PARAM_BITS-1:0] store [MAX_PARAMS];

  logic [7:0]            fch;
  logic                  fq;
  logic [CW-1:0]         fcnt;
  logic [IW-1:0]         idx;

  tesp_pkg::kind_t       out_kind;
  logic [7:0]            out_char;
  logic                  out_pf;
  logic [4:0]            out_cnt;
  logic [3:0]            out_idx;
  logic [15:0]           out_val;
  logic                  out_last;

  logic [CW-1:0]         cnt;
  logic                  full;
  logic                  push_ok;
  logic [IW-1:0]         uidx;
  logic [XW-1:0]         prod;
  logic [PARAM_BITS-1:0] sat;
  logic [PARAM_BITS-1:0] head;

  assign cnt     = used + CW'(pending);
  assign full    = (used == CW'(MAX_PARAMS));
  assign push_ok = (pushed < PW'(STACK_DEPTH));
  assign uidx    = IW'(used);
  assign prod    = XW'(cur_val) * XW'(10) + XW'(ch[3:0]);
  assign sat     = (prod > XW'(MAXV)) ? MAXV : PARAM_BITS'(prod);
  assign head    = (used == '0) ? cur_val : store[0];

  always_comb begin
    sts.is_esc    = (ch == tesp_pkg::CH_ESC);
    sts.is_lbr    = (ch == tesp_pkg::CH_LBR);
    sts.is_hash   = (ch == tesp_pkg::CH_HASH);
    sts.is_paren  = (ch == tesp_pkg::CH_LPAREN) || (ch == tesp_pkg::CH_RPAREN);
    sts.is_digit  = (ch >= tesp_pkg::CH_0) && (ch <= tesp_pkg::CH_9);
    sts.is_q      = (ch == tesp_pkg::CH_QMARK);
    sts.is_semi   = (ch == tesp_pkg::CH_SEMI);
    sts.esc_final = (ch >= tesp_pkg::CH_0) && (ch <= tesp_pkg::CH_Z);
    sts.csi_final = (ch >= tesp_pkg::CH_AT) && (ch <= tesp_pkg::CH_Z);
    sts.cs_ok     = (ch >= tesp_pkg::CH_0) && (ch <= tesp_pkg::CH_B);
    sts.out_free  = !m_tvalid || m_tready;
    sts.cnt_le1   = (cnt <= CW'(1));
    sts.emit_last = ((CW + 1)'(idx) + (CW + 1)'(1)) == (CW + 1)'(fcnt);
  end

  // Parameter list state.
  always_ff @(posedge clk) begin
    if (rst) begin
      question <= 1'b0;
      pushed   <= '0;
      used     <= '0;
      pending  <= 1'b0;
    end else if (cmd.open_csi || cmd.csi_start) begin
      question <= 1'b0;
      pushed   <= '0;
      used     <= '0;
      pending  <= 1'b0;
    end else if (cmd.set_q) begin
      question <= 1'b1;
    end else if (cmd.push && push_ok) begin
      pushed <= pushed + PW'(1);
      if (ch == tesp_pkg::CH_SEMI) begin
        pending <= 1'b0;
        if (!full) begin
          used <= used + CW'(1);
        end
      end else if (!full) begin
        pending <= 1'b1;
      end
    end
  end

  // Accumulator and parameter store; an open slot lives in cur_val until closed.
  always_ff @(posedge clk) begin
    if (cmd.open_csi) begin
      cur_val <= '0;
    end else if (cmd.push && push_ok && !full) begin
      if (ch == tesp_pkg::CH_SEMI) begin
        store[uidx] <= cur_val;
        cur_val     <= '0;
      end else begin
        cur_val <= sat;
      end
    end else if (cmd.csi_start && pending) begin
      store[uidx] <= cur_val;
    end
  end

  // Emission bookkeeping.
  always_ff @(posedge clk) begin
    if (cmd.csi_start) begin
      fch  <= ch;
      fq   <= question;
      fcnt <= cnt;
      idx  <= IW'(1);
    end else if (cmd.csi_next) begin
      idx <= idx + IW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load || cmd.csi_start || cmd.csi_next) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind <= cmd.out_kind;
      out_char <= ch;
      out_pf   <= 1'b0;
      out_cnt  <= '0;
      out_idx  <= '0;
      out_val  <= '0;
      out_last <= 1'b1;
    end else if (cmd.csi_start) begin
      out_kind <= tesp_pkg::KIND_CSI;
      out_char <= ch;
      out_pf   <= question;
      out_cnt  <= 5'(cnt);
      out_idx  <= '0;
      out_val  <= (cnt == '0) ? 16'd0 : 16'(head);
      out_last <= (cnt <= CW'(1));
    end else if (cmd.csi_next) begin
      out_kind <= tesp_pkg::KIND_CSI;
      out_char <= fch;
      out_pf   <= fq;
      out_cnt  <= 5'(fcnt);
      out_idx  <= 4'(idx);
      out_val  <= 16'(store[idx]);
      out_last <= sts.emit_last;
    end
  end

  assign m_tdata = {6'd0, out_val, out_idx, out_cnt, out_pf, out_char};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

### rtl/terminal_escape_sequence_parser_unit.sv
// Top level of the terminal escape sequence parser: controller, datapath and checks.
//
//   channel | dir | transfer carries
//   s_*     | in  | one byte of the terminal stream (tdata[7:0])
//   m_*     | out | one event: kind in tuser, char/flag/count/index/value in tdata,
//           |     | tlast on the final event caused by one input byte
//
// The input takes one byte per cycle while the output register is free; a result
// appears in the output register the cycle after its byte is taken. A CSI final byte
// with N parameters holds the input while the stored parameters go out one per cycle,
// as the output allows, through the same register. Reset clears the mode, the CSI
// list state and the output valid. A stalled output stalls the input.
module terminal_escape_sequence_parser_unit #(
  parameter int STACK_DEPTH = tesp_pkg::STACK_DEPTH_DEF,
  parameter int MAX_PARAMS  = tesp_pkg::MAX_PARAMS_DEF,
  parameter int PARAM_BITS  = tesp_pkg::PARAM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] out_char, [8] private_flag, [13:9] param_count,
                                 // [17:14] param_index, [33:18] param_value, rest zero
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast
);

  tesp_pkg::cmd_t cmd;
  tesp_pkg::sts_t sts;

  // Decode the mode and byte class into one command per cycle.
  tesp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the parameter list and drive the result register.
  tesp_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_PARAMS  (MAX_PARAMS),
    .PARAM_BITS  (PARAM_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ch       (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTHESIS
  // A full, stalled result register must block new bytes.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result register is stalled");

  // While a parameter list is still going out, no new byte is taken.
  a_list_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |-> !s_tready)
    else $error("input taken in the middle of a parameter list");

  // Only CSI events come in multi-result runs.
  a_single_non_csi: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != tesp_pkg::KIND_CSI)) |-> (m_tlast && (m_tdata[33:8] == 26'd0)))
    else $error("non-CSI event with parameter fields or without last");
`endif

endmodule

### test/testbench.sv
// Self-checking testbench for the terminal escape sequence parser stream unit.
`timescale 1ns / 1ps

module testbench;

  localparam int PAR_MAX = (1 << tesp_pkg::PARAM_BITS_DEF) - 1;

  typedef enum logic [2:0] {
    PM_IDLE,
    PM_ESC,
    PM_CSI,
    PM_HASH,
    PM_CHARSET
  } parse_mode_t;

  // One parser event as it leaves the block.
  typedef struct packed {
    tesp_pkg::kind_t kind;
    logic [7:0]      chr;
    logic            priv;
    logic [4:0]      count;
    logic [3:0]      index;
    logic [15:0]     value;
    logic            last;
  } parser_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  terminal_escape_sequence_parser_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #2 clk = ~clk;

  // Stimulus and bookkeeping.
  logic [7:0]    stream_bytes[$];
  parser_event_t events_due[$];
  int            n_stream;
  int            bytes_taken;
  int            results_seen;
  int            errors;
  int            csi_dispatches;
  int            longest_list;
  int            input_stalls;

  // Parser state as predicted.
  parse_mode_t   pm_mode = PM_IDLE;
  logic          pm_qmark;
  int            pm_pushed;
  int            pm_used;
  logic          pm_digit;
  logic [15:0]   pm_store [tesp_pkg::MAX_PARAMS_DEF];

  // Transfers seen at the last rising edge.
  logic s_fire = 1'b0;
  logic m_fire = 1'b0;

  int   send_gap;
  bit   send_calm;
  int   recv_wait;
  bit   recv_calm;
  bit   hold_done;

  function automatic void queue_event(tesp_pkg::kind_t k, logic [7:0] c, logic pf, int cnt,
                                      int idx, logic [15:0] val, logic lst);
    parser_event_t e;
    e.kind  = k;
    e.chr   = c;
    e.priv  = pf;
    e.count = 5'(cnt);
    e.index = 4'(idx);
    e.value = val;
    e.last  = lst;
    events_due.push_back(e);
  endfunction

  // Fold a digit or separator into the parameter list.
  function automatic void fold_param_byte(logic [7:0] c);
    int v;
    if (pm_pushed >= tesp_pkg::STACK_DEPTH_DEF) return;
    pm_pushed++;
    if (c == tesp_pkg::CH_SEMI) begin
      pm_digit = 1'b0;
      if (pm_used < tesp_pkg::MAX_PARAMS_DEF) begin
        pm_used++;
        if (pm_used < tesp_pkg::MAX_PARAMS_DEF) pm_store[pm_used] = '0;
      end
    end else if (pm_used < tesp_pkg::MAX_PARAMS_DEF) begin
      v = int'(pm_store[pm_used]) * 10 + int'(c - tesp_pkg::CH_0);
      pm_store[pm_used] = (v > PAR_MAX) ? 16'(PAR_MAX) : 16'(v);
      pm_digit = 1'b1;
    end
  endfunction

  // Advance the predicted parser by one byte and queue the events it causes.
  function automatic void parse_byte(logic [7:0] c);
    bit is_dig;
    int cnt;
    is_dig = (c >= tesp_pkg::CH_0) && (c <= tesp_pkg::CH_9);
    case (pm_mode)
      PM_IDLE: begin
        if (c == tesp_pkg::CH_ESC) begin
          pm_mode = PM_ESC;
          return;
        end
      end
      PM_ESC: begin
        if (c == tesp_pkg::CH_LBR) begin
          pm_mode   = PM_CSI;
          pm_qmark  = 1'b0;
          pm_pushed = 0;
          pm_used   = 0;
          pm_digit  = 1'b0;
          pm_store[0] = '0;
          return;
        end
        if (c == tesp_pkg::CH_HASH) begin
          pm_mode = PM_HASH;
          return;
        end
        if (c == tesp_pkg::CH_LPAREN || c == tesp_pkg::CH_RPAREN) begin
          pm_mode = PM_CHARSET;
          return;
        end
        if (c >= tesp_pkg::CH_0 && c <= tesp_pkg::CH_Z) begin
          pm_mode = PM_IDLE;
          queue_event(tesp_pkg::KIND_ESC, c, 1'b0, 0, 0, '0, 1'b1);
          return;
        end
      end
      PM_HASH: begin
        if (is_dig) begin
          pm_mode = PM_IDLE;
          queue_event(tesp_pkg::KIND_HASH, c, 1'b0, 0, 0, '0, 1'b1);
          return;
        end
      end
      PM_CHARSET: begin
        // Any byte closes the designator.
        pm_mode = PM_IDLE;
        queue_event((c >= tesp_pkg::CH_0 && c <= tesp_pkg::CH_B) ?
                    tesp_pkg::KIND_CS_OK : tesp_pkg::KIND_CS_BAD,
                    c, 1'b0, 0, 0, '0, 1'b1);
        return;
      end
      PM_CSI: begin
        if (c == tesp_pkg::CH_QMARK) begin
          pm_qmark = 1'b1;
          return;
        end
        if (c == tesp_pkg::CH_SEMI || is_dig) begin
          fold_param_byte(c);
          return;
        end
        if (c >= tesp_pkg::CH_AT && c <= tesp_pkg::CH_Z) begin
          cnt = pm_used + int'(pm_digit);
          if (cnt > tesp_pkg::MAX_PARAMS_DEF) cnt = tesp_pkg::MAX_PARAMS_DEF;
          if (cnt == 0) begin
            queue_event(tesp_pkg::KIND_CSI, c, pm_qmark, 0, 0, '0, 1'b1);
          end else begin
            for (int i = 0; i < cnt; i++)
              queue_event(tesp_pkg::KIND_CSI, c, pm_qmark, cnt, i, pm_store[i],
                          i + 1 == cnt);
          end
          csi_dispatches++;
          if (cnt > longest_list) longest_list = cnt;
          pm_mode   = PM_IDLE;
          pm_qmark  = 1'b0;
          pm_pushed = 0;
          pm_used   = 0;
          pm_digit  = 1'b0;
          return;
        end
      end
      default: pm_mode = PM_IDLE;
    endcase
    // Bytes that fit nowhere are printed; an open sequence stays open.
    queue_event(tesp_pkg::KIND_PRINT, c, 1'b0, 0, 0, '0, 1'b1);
  endfunction

  function automatic void check_event();
    parser_event_t got;
    parser_event_t want;
    got.kind  = tesp_pkg::kind_t'(m_tuser);
    got.chr   = m_tdata[7:0];
    got.priv  = m_tdata[8];
    got.count = m_tdata[13:9];
    got.index = m_tdata[17:14];
    got.value = m_tdata[33:18];
    got.last  = m_tlast;
    results_seen++;
    if (events_due.size() == 0) begin
      if (errors < 10)
        $display("ERROR: unexpected result kind=%0d char=%h pf=%b cnt=%0d idx=%0d val=%0d last=%b",
                 got.kind, got.chr, got.priv, got.count, got.index, got.value, got.last);
      errors++;
      return;
    end
    want = events_due.pop_front();
    if (got !== want) begin
      if (errors < 10) begin
        $display("ERROR: result %0d mismatch", results_seen);
        $display("  expected kind=%0d char=%h pf=%b cnt=%0d idx=%0d val=%0d last=%b",
                 want.kind, want.chr, want.priv, want.count, want.index, want.value, want.last);
        $display("  actual   kind=%0d char=%h pf=%b cnt=%0d idx=%0d val=%0d last=%b",
                 got.kind, got.chr, got.priv, got.count, got.index, got.value, got.last);
      end
      errors++;
    end
  endfunction

  // Sample both channels at the rising edge; predict on input transfers.
  always @(posedge clk) begin
    s_fire <= s_tvalid && s_tready && !rst;
    m_fire <= m_tvalid && m_tready && !rst;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata);
        bytes_taken++;
      end
      if (s_tvalid && !s_tready) input_stalls++;
      if (m_tvalid && m_tready) check_event();
    end
  end

  // Byte driver: hold the current byte until its transfer, then idle or offer the next.
  always @(negedge clk) begin
    if (!rst && !(s_tvalid && !s_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (stream_bytes.size() > 0) begin
        s_tdata  <= stream_bytes.pop_front();
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 6);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: after a transfer, stall at random; once, hold off long enough to back up the input.
  always @(negedge clk) begin
    if (!rst) begin
      if (m_fire) begin
        if (!hold_done && results_seen >= 40) begin
          recv_wait = 150;
          hold_done = 1'b1;
        end else begin
          if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
          recv_wait = recv_calm ? 0 : $urandom_range(0, 6);
        end
      end
      if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic put_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
  endtask

  // CSI sequence: mostly short lists, now and then a long one that may overflow the limits.
  task automatic add_csi();
    int  n_par;
    int  n_dig;
    bit  big;
    big = ($urandom_range(0, 7) == 0);
    put_byte(tesp_pkg::CH_ESC);
    put_byte(tesp_pkg::CH_LBR);
    if ($urandom_range(0, 2) == 0) put_byte(tesp_pkg::CH_QMARK);
    n_par = big ? $urandom_range(10, 20) : $urandom_range(0, 4);
    for (int i = 0; i < n_par; i++) begin
      if (i > 0) put_byte(tesp_pkg::CH_SEMI);
      if (big) n_dig = $urandom_range(0, 3);
      else if ($urandom_range(0, 6) == 0) n_dig = $urandom_range(5, 7);
      else n_dig = $urandom_range(0, 3);
      for (int j = 0; j < n_dig; j++) put_byte(8'(tesp_pkg::CH_0 + $urandom_range(0, 9)));
      if ($urandom_range(0, 19) == 0) put_byte(tesp_pkg::CH_QMARK);
      if ($urandom_range(0, 24) == 0) put_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 4) == 0) put_byte(tesp_pkg::CH_SEMI);
    put_byte(8'($urandom_range(tesp_pkg::CH_AT, tesp_pkg::CH_Z)));
  endtask

  task automatic add_sequence();
    int          pick;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      add_csi();
    end else if (pick < 45) begin
      b = 8'($urandom_range(tesp_pkg::CH_0, tesp_pkg::CH_Z));
      if (b == tesp_pkg::CH_LBR) b = tesp_pkg::CH_Z;
      put_byte(tesp_pkg::CH_ESC);
      put_byte(b);
    end else if (pick < 53) begin
      put_byte(tesp_pkg::CH_ESC);
      put_byte(tesp_pkg::CH_HASH);
      put_byte(8'(tesp_pkg::CH_0 + $urandom_range(0, 9)));
    end else if (pick < 63) begin
      put_byte(tesp_pkg::CH_ESC);
      put_byte($urandom_range(0, 1) ? tesp_pkg::CH_LPAREN : tesp_pkg::CH_RPAREN);
      put_byte($urandom_range(0, 1) ?
               8'($urandom_range(tesp_pkg::CH_0, tesp_pkg::CH_B)) :
               8'($urandom_range(0, 255)));
    end else if (pick < 78) begin
      // plain text, no escapes
      repeat ($urandom_range(1, 4)) begin
        b = 8'($urandom_range(0, 255));
        put_byte(b == tesp_pkg::CH_ESC ? 8'h20 : b);
      end
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      // broken sequence: an opener followed by a byte that may not fit
      put_byte(tesp_pkg::CH_ESC);
      case ($urandom_range(0, 2))
        0: put_byte(tesp_pkg::CH_HASH);
        1: put_byte(tesp_pkg::CH_LBR);
        default: ;
      endcase
      put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    // Directed: byte extremes, each dispatch kind, empty CSI, private CSI with a
    // trailing separator and a high byte printed inside the open sequence.
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(tesp_pkg::CH_ESC); put_byte(tesp_pkg::CH_Z);
    put_byte(tesp_pkg::CH_ESC); put_byte(tesp_pkg::CH_HASH); put_byte(8'h38);
    put_byte(tesp_pkg::CH_ESC); put_byte(tesp_pkg::CH_LPAREN); put_byte(tesp_pkg::CH_B);
    put_byte(tesp_pkg::CH_ESC); put_byte(tesp_pkg::CH_RPAREN); put_byte(tesp_pkg::CH_Z);
    put_byte(tesp_pkg::CH_ESC); put_byte(tesp_pkg::CH_LBR); put_byte(8'h6D);
    put_byte(tesp_pkg::CH_ESC); put_byte(tesp_pkg::CH_LBR); put_byte(tesp_pkg::CH_QMARK);
    put_byte(8'h31);
    put_byte(tesp_pkg::CH_SEMI); put_byte(8'h80); put_byte(8'h68);

    while (stream_bytes.size() < 310) add_sequence();
    n_stream = stream_bytes.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (bytes_taken < n_stream) @(posedge clk);
    while (events_due.size() > 0) @(posedge clk);
    // Let any stray trailing result show up.
    repeat (20) @(posedge clk);

    $display("Run covered %0d bytes and %0d results, %0d CSI dispatches (longest list %0d).",
             bytes_taken, results_seen, csi_dispatches, longest_list);
    $display("Input was held off for %0d cycles; %0d mismatches.", input_stalls, errors);
    if (errors == 0 && events_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
